### rtl/core/uart_motor_gpio_command_bridge_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor and GPIO command bridge
// These are shared property templates. Each one checks a condition on the
// rising edge of the given clock and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UART_MOTOR_GPIO_COMMAND_BRIDGE_UNIT_ASSERT_SVH
`define UART_MOTOR_GPIO_COMMAND_BRIDGE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UMGCB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UMGCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/umgcb_pkg.sv
// ----------------------------------------------------------------------------
// umgcb_pkg
// Shared types and constants of the UART motor and GPIO command bridge.
// ----------------------------------------------------------------------------
`default_nettype none

package umgcb_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int GPIO_COUNT  = 8;
    localparam int MAX_RESULTS = 4;

    // Command byte patterns.
    localparam logic [7:0] CMD_MASK     = 8'hF0;
    localparam logic [7:0] CMD_MOTOR    = 8'hC0;
    localparam logic [7:0] CMD_GPIO     = 8'hA0;
    localparam logic [7:0] CMD_RESET    = 8'hE1;
    localparam logic [7:0] CMD_RESET_R  = 8'h72;
    localparam logic [7:0] TX_DONE_BASE = 8'hD0;

    // Event kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Parser phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] motor_drive;
        logic [7:0] gpio_levels;
        logic       last;
    } t_out;

    // Everything one event produces: up to four bytes to send and the
    // pin state after the event.
    typedef struct packed {
        logic                  has_tx;
        logic [1:0]            last_idx;
        logic [3:0][7:0]       bytes;
        logic [7:0]            drive;
        logic [7:0]            gpio;
    } t_bundle;

endpackage

`default_nettype wire

### rtl/core/umgcb_ctrl.sv
// ----------------------------------------------------------------------------
// umgcb_ctrl
// Command parser, motor countdowns and expander levels. Updates the state on
// each accepted event and presents the resulting bundle in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module umgcb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire umgcb_pkg::t_in    i_in,
    output umgcb_pkg::t_bundle     o_bundle
);

    logic [umgcb_pkg::MOTOR_COUNT-1:0]       r_running;
    logic [umgcb_pkg::MOTOR_COUNT-1:0][15:0] r_remaining;
    logic [7:0]                              r_drive;
    logic [7:0]                              r_gpio;
    logic [1:0]                              r_phase;
    logic [7:0]                              r_pending;
    logic [7:0]                              r_low;

    logic [umgcb_pkg::MOTOR_COUNT-1:0]       n_running;
    logic [umgcb_pkg::MOTOR_COUNT-1:0][15:0] n_remaining;
    logic [7:0]                              n_drive;
    logic [7:0]                              n_gpio;
    logic [1:0]                              n_phase;
    logic [7:0]                              n_pending;
    logic [7:0]                              n_low;

    always_comb begin
        logic [2:0]  cnt;
        logic [1:0]  mot;
        logic [2:0]  pin;
        logic [15:0] dur;
        logic [7:0]  c;

        n_running   = r_running;
        n_remaining = r_remaining;
        n_drive     = r_drive;
        n_gpio      = r_gpio;
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_low       = r_low;
        o_bundle    = '0;
        cnt         = 3'd0;
        c           = i_in.rx_byte;
        mot         = r_pending[2:1];
        pin         = c[3:1];
        dur         = {c, r_low};

        if (i_in.kind == umgcb_pkg::KIND_TICK) begin
            for (int m = 0; m < umgcb_pkg::MOTOR_COUNT; m++) begin
                if (r_running[m]) begin
                    n_remaining[m] = r_remaining[m] - 16'd1;
                    if (r_remaining[m] == 16'd1) begin
                        n_running[m]       = 1'b0;
                        n_drive[2*m +: 2]  = 2'b00;
                        o_bundle.bytes[cnt[1:0]] = umgcb_pkg::TX_DONE_BASE | 8'(m);
                        cnt = cnt + 3'd1;
                    end
                end
            end
        end else if (r_phase == umgcb_pkg::PH_LOW) begin
            n_low   = c;
            n_phase = umgcb_pkg::PH_HIGH;
        end else if (r_phase == umgcb_pkg::PH_HIGH) begin
            n_phase = umgcb_pkg::PH_IDLE;
            for (int m = 0; m < umgcb_pkg::MOTOR_COUNT; m++) begin
                if (mot == 2'(m)) begin
                    if (dur == 16'd0) begin
                        n_running[m]      = 1'b0;
                        n_remaining[m]    = 16'd0;
                        n_drive[2*m +: 2] = 2'b00;
                    end else begin
                        n_running[m]      = 1'b1;
                        n_remaining[m]    = dur;
                        n_drive[2*m +: 2] = r_pending[0] ? 2'b10 : 2'b01;
                        o_bundle.bytes[0] = r_pending;
                        cnt = 3'd1;
                    end
                end
            end
        end else begin
            n_phase = umgcb_pkg::PH_IDLE;
            if ((c & umgcb_pkg::CMD_MASK) == umgcb_pkg::CMD_MOTOR) begin
                n_pending = c;
                n_phase   = umgcb_pkg::PH_LOW;
            end else if ((c & umgcb_pkg::CMD_MASK) == umgcb_pkg::CMD_GPIO) begin
                if (int'(pin) < umgcb_pkg::GPIO_COUNT) begin
                    n_gpio[pin]       = c[0];
                    o_bundle.bytes[0] = c;
                    cnt = 3'd1;
                end
            end else if (c == umgcb_pkg::CMD_RESET || c == umgcb_pkg::CMD_RESET_R) begin
                n_running         = '0;
                n_remaining       = '0;
                n_drive           = '0;
                n_gpio            = '0;
                n_phase           = umgcb_pkg::PH_IDLE;
                n_pending         = '0;
                n_low             = '0;
                o_bundle.bytes[0] = umgcb_pkg::CMD_RESET;
                cnt = 3'd1;
            end
        end

        o_bundle.has_tx   = (cnt != 3'd0);
        o_bundle.last_idx = (cnt == 3'd0) ? 2'd0 : 2'(cnt - 3'd1);
        o_bundle.drive    = n_drive;
        o_bundle.gpio     = n_gpio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_remaining <= '0;
            r_drive     <= '0;
            r_gpio      <= '0;
            r_phase     <= umgcb_pkg::PH_IDLE;
            r_pending   <= '0;
            r_low       <= '0;
        end else if (i_accept) begin
            r_running   <= n_running;
            r_remaining <= n_remaining;
            r_drive     <= n_drive;
            r_gpio      <= n_gpio;
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_low       <= n_low;
        end
    end

endmodule

`default_nettype wire

### rtl/core/umgcb_txseq.sv
// ----------------------------------------------------------------------------
// umgcb_txseq
// Result register. Holds the bundle of one event and hands out its results
// one per cycle while the output is not stalled. It can take the next bundle
// in the cycle its last result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module umgcb_txseq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire umgcb_pkg::t_bundle i_bundle,
    output logic                    o_free,
    output logic                    o_out_valid,
    output umgcb_pkg::t_out         o_out,
    input  wire logic               i_out_stall
);

    logic               r_full;
    logic [1:0]         r_idx;
    umgcb_pkg::t_bundle r_b;

    logic pop;
    logic done;

    assign pop    = r_full && !i_out_stall;
    assign done   = pop && (r_idx == r_b.last_idx);
    assign o_free = !r_full || done;

    assign o_out_valid       = r_full;
    assign o_out.tx_valid    = r_b.has_tx;
    assign o_out.tx_byte     = r_b.has_tx ? r_b.bytes[r_idx] : 8'd0;
    assign o_out.motor_drive = r_b.drive;
    assign o_out.gpio_levels = r_b.gpio;
    assign o_out.last        = (r_idx == r_b.last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_full <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_full <= 1'b0;
            r_idx  <= 2'd0;
        end else if (pop) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= i_bundle;
        end
    end

endmodule

`default_nettype wire

### rtl/core/uart_motor_gpio_command_bridge_unit.sv
// ----------------------------------------------------------------------------
// uart_motor_gpio_command_bridge_unit
// Turns received UART bytes and millisecond ticks into motor drive, expander
// levels and reply bytes.
// ----------------------------------------------------------------------------
// Each input item is one event: a received byte or a one millisecond tick.
// The event is decoded and the state updated in the cycle it is accepted, and
// its results land in a result register that sends them one per cycle unless
// the output stalls. Most events give exactly one result; a tick on which
// several countdowns expire gives one result per expiring motor, up to four,
// in motor order. A new item is taken in the same cycle the last result of
// the previous one leaves, so a new event waits until all results of the
// previous one are out. Only the result register holds the input back.
// Every result carries the motor drive and expander levels as they stand
// after the whole event; last marks the final result of the event.
`default_nettype none

module uart_motor_gpio_command_bridge_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire umgcb_pkg::t_in   i_in,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output umgcb_pkg::t_out       o_out,
    input  wire logic             i_out_stall
);

`include "uart_motor_gpio_command_bridge_unit_assert.svh"

    umgcb_pkg::t_bundle bundle;
    logic               free;
    logic               accept;

    // An item is taken whenever the result register is empty or is handing
    // out its final result in this cycle.
    assign o_in_stall = !free;
    assign accept     = i_in_valid && free;

    umgcb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_bundle (bundle)
    );

    umgcb_txseq u_txseq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_bundle    (bundle),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // A result that is not the last of its event must be followed by more.
    `UMGCB_ASSERT_NEXT(a_more_follow, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out.last, o_out_valid, "results of an event were cut short")
    // An event that sends nothing has exactly one result.
    `UMGCB_ASSERT_SAME(a_silent_single, i_clk, i_rst_n, o_out_valid && !o_out.tx_valid, o_out.last && o_out.tx_byte == 8'd0, "silent result must be single and zero")
    // A new item never enters while earlier results are still pending.
    `UMGCB_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, i_in_valid && !o_in_stall, !o_out_valid || (o_out.last && !i_out_stall), "item accepted over pending results")

endmodule

`default_nettype wire
